// ===== design/two_d_parity_block_corrector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D parity block corrector
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_D_PARITY_BLOCK_CORRECTOR_UNIT_MACROS_SVH
`define TWO_D_PARITY_BLOCK_CORRECTOR_UNIT_MACROS_SVH

// property checked while out of reset
`define TDPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tdpc assertion failed");

// property checked at every edge, reset included
`define TDPC_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tdpc assertion failed");

`endif

// ===== design/tdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpc_pkg
// Types and constants shared by the corrector top level and its cells.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int BYTE_W = 8;

  // byte offered to a cell when a block is handed to the output chain
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              lor;    // last beat of this run
    logic              eom;    // last beat of the message
  } tdpc_load_t;

  // per-block correction controls, common to all cells
  typedef struct packed {
    logic              fix_en;
    logic              chk;
    logic [BYTE_W-1:0] mask;
  } tdpc_blk_t;

  // contents of one output cell
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              lor;
    logic              eom;
    logic              corr;
    logic              chk;
  } tdpc_beat_t;

endpackage

// ===== design/tdpc_cell.sv =====
// ----------------------------------------------------------------------------
// tdpc_cell
// One output chain cell: takes a block byte, applies the correction if it is
// the first odd row, then shifts toward the head one beat per pop.
// ----------------------------------------------------------------------------
module tdpc_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               pop,
  input  logic               parity_en,
  input  tdpc_pkg::tdpc_load_t ld,
  input  tdpc_pkg::tdpc_blk_t  blk,
  input  tdpc_pkg::tdpc_beat_t next_in,
  input  logic               seen_in,
  output logic               seen_out,
  output tdpc_pkg::tdpc_beat_t beat
);
  import tdpc_pkg::*;

  logic odd;
  logic fix;

  assign odd      = parity_en & (^ld.data);
  assign fix      = blk.fix_en & odd & ~seen_in;   // first odd row only
  assign seen_out = seen_in | odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (load) begin
      beat.valid <= ld.valid;
    end else if (pop) begin
      beat.valid <= next_in.valid;
    end
    // payload needs no reset, valid qualifies it
    if (load) begin
      beat.data <= ld.data ^ (fix ? blk.mask : '0);
      beat.lor  <= ld.lor;
      beat.eom  <= ld.eom;
      beat.corr <= fix;
      beat.chk  <= blk.chk;
    end else if (pop) begin
      beat.data <= next_in.data;
      beat.lor  <= next_in.lor;
      beat.eom  <= next_in.eom;
      beat.corr <= next_in.corr;
      beat.chk  <= next_in.chk;
    end
  end

endmodule

// ===== design/two_d_parity_block_corrector_unit.sv =====
// ----------------------------------------------------------------------------
// two_d_parity_block_corrector_unit
// Two-dimensional parity single-error corrector over blocks of data bytes
// plus one column parity byte.
// ----------------------------------------------------------------------------
//  channel   | signals                          | role
//  ----------+----------------------------------+------------------------------
//  s_ (in)   | s_tvalid s_tready s_tdata s_tlast| received bytes, tlast = msg end
//  m_ (out)  | m_tvalid m_tready m_tdata m_tlast| block bytes, tlast = run end
//            | m_tuser                          | eom / corrected / check error
//  cfg       | cfg_we cfg_wdata                 | correct_first_only register
//
//  One input beat per cycle while s_tready is high. A block's bytes sit
//  in a small store until its parity byte (or a message end) arrives;
//  that beat loads all bytes in parallel into a chain of cells that
//  drains one beat per cycle from the head while m_tready is high,
//  starting the cycle after the load. s_tready drops only on a
//  block-ending beat while the chain still holds more than its head beat
//  or its head beat is stalled, so input and output overlap fully.
//  rst is synchronous: counters, syndrome, fix flag and chain valid bits
//  clear; correct_first_only returns to 1.
// ----------------------------------------------------------------------------
module two_d_parity_block_corrector_unit #(
  parameter int DATA_ROWS = 6
) (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_we,
  input  logic       cfg_wdata,     // correct_first_only
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] data_byte
  input  logic       s_tlast,       // last_in_message
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,       // [7:0] out_byte
  output logic       m_tlast,       // last_of_run
  output logic [2:0] m_tuser        // [0] end_of_message [1] was_corrected [2] check_error
);
  import tdpc_pkg::*;

  localparam int BLOCK_LEN = DATA_ROWS + 1;
  localparam int CNT_W     = $clog2(BLOCK_LEN);

  logic                  correct_first_only;
  logic [CNT_W-1:0]      fill_count;
  logic [BYTE_W-1:0]     column_syndrome;
  logic                  fixed_in_message;
  logic [BYTE_W-1:0]     store [DATA_ROWS];

  tdpc_beat_t            beats [BLOCK_LEN];
  tdpc_beat_t            next_beat [BLOCK_LEN];
  tdpc_load_t            lds [BLOCK_LEN];
  logic [BLOCK_LEN:0]    seen;
  tdpc_blk_t             blk;

  logic                  accept;
  logic                  full;
  logic                  ends_block;
  logic                  load;
  logic                  pop;
  logic                  out_free;
  logic [BYTE_W-1:0]     syn;
  logic                  any_odd;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign full       = (fill_count == CNT_W'(DATA_ROWS));
  assign ends_block = full | s_tlast;
  assign pop        = beats[0].valid & m_tready;
  // chain is free for a new block once it is empty after this edge's pop
  assign out_free   = ~beats[1].valid & (~beats[0].valid | m_tready);
  assign s_tready   = out_free | ~ends_block;
  assign accept     = s_tvalid & s_tready;
  assign load       = accept & ends_block;

  // --------------------------------------------------------------------------
  // Block check: syndrome over all bytes, lowest set bit picks the column
  // --------------------------------------------------------------------------
  assign syn     = column_syndrome ^ s_tdata;
  assign any_odd = seen[BLOCK_LEN];

  always_comb begin
    blk.fix_en = full & (syn != '0) & ~(correct_first_only & fixed_in_message);
    blk.mask   = syn & (~syn + BYTE_W'(1));
    blk.chk    = blk.fix_en & ~any_odd;
  end

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      correct_first_only <= 1'b1;
    end else if (cfg_we) begin
      correct_first_only <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Block control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      column_syndrome  <= '0;
      fixed_in_message <= 1'b0;
    end else if (accept) begin
      if (ends_block) begin
        fill_count      <= '0;
        column_syndrome <= '0;
      end else begin
        fill_count      <= fill_count + CNT_W'(1);
        column_syndrome <= syn;
      end
      if (s_tlast) begin
        fixed_in_message <= 1'b0;
      end else if (load & blk.fix_en & any_odd) begin
        fixed_in_message <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Data row store and output cell chain
  // --------------------------------------------------------------------------
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < BLOCK_LEN; i++) begin : g_row
    if (i < DATA_ROWS) begin : g_data
      always_ff @(posedge clk) begin
        if (accept && fill_count == CNT_W'(i)) begin
          store[i] <= s_tdata;
        end
      end
      assign lds[i].data = (fill_count == CNT_W'(i)) ? s_tdata : store[i];
    end else begin : g_par
      assign lds[i].data = s_tdata;
    end

    assign lds[i].valid = (CNT_W'(i) <= fill_count);
    assign lds[i].lor   = (fill_count == CNT_W'(i));
    assign lds[i].eom   = (fill_count == CNT_W'(i)) & s_tlast;

    if (i == BLOCK_LEN - 1) begin : g_tail
      assign next_beat[i] = '0;
    end else begin : g_mid
      assign next_beat[i] = beats[i+1];
    end

    tdpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .pop       (pop),
      .parity_en (i < DATA_ROWS),
      .ld        (lds[i]),
      .blk       (blk),
      .next_in   (next_beat[i]),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .beat      (beats[i])
    );
  end

  // --------------------------------------------------------------------------
  // Output beat from the head cell
  // --------------------------------------------------------------------------
  assign m_tvalid = beats[0].valid;
  assign m_tdata  = beats[0].data;
  assign m_tlast  = beats[0].lor;
  assign m_tuser  = {beats[0].chk, beats[0].corr, beats[0].eom};

endmodule

// ===== design/tdpc_checker.sv =====
// ----------------------------------------------------------------------------
// tdpc_checker
// Port-level checks of the 2-D parity corrector, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_d_parity_block_corrector_unit_macros.svh"

module tdpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [2:0] m_tuser
);

  // stalled beat holds
  `TDPC_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // a fix and a check error never mark the same byte
  `TDPC_ASSERT(a_fix_xor_chk, clk, rst, !(m_tvalid && m_tuser[1] && m_tuser[2]))
  // message end only on the last beat of a run
  `TDPC_ASSERT(a_eom_last, clk, rst, m_tvalid && m_tuser[0] |-> m_tlast)
  // reset empties the output chain
  `TDPC_ASSERT_ALL(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind two_d_parity_block_corrector_unit tdpc_checker u_tdpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/tdpc_checker.sv =====
// ----------------------------------------------------------------------------
// tdpc_scoreboard
// Watches the corrector's config, input and output channels. Predicts the
// beats each accepted input byte releases and compares them in order.
// ----------------------------------------------------------------------------
module tdpc_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,
  input  logic              m_tlast,
  input  logic [2:0]        m_tuser,
  output int unsigned       fail_count,
  output int unsigned       beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_ROWS = 6;
  localparam int BLOCK_LEN = DATA_ROWS + 1;
  // m_tuser bit positions
  localparam int EOM_BIT  = 0;
  localparam int CORR_BIT = 1;
  localparam int CHK_BIT  = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       lor;
    logic       eom;
    logic       corr;
    logic       chk;
  } out_beat_t;

  out_beat_t            corrected_due[$];
  logic [7:0]           held_bytes[BLOCK_LEN];
  logic [2:0]           fill_idx;
  logic [7:0]           col_syndrome;
  logic [DATA_ROWS-1:0] row_odd;
  logic                 fixed_this_msg;
  logic                 first_fix_only;
  int unsigned          errors;
  out_beat_t            got;
  out_beat_t            want;

  // Store one byte; on a block or message end, queue the beats it releases.
  task automatic correct_block_byte(input logic [7:0] b, input logic last);
    int        count;
    int        fix_row;
    int        bit_pos;
    logic [7:0] mask;
    logic      chk;
    out_beat_t bt;
    count   = 0;
    fix_row = -1;
    mask    = 8'h00;
    chk     = 1'b0;
    held_bytes[fill_idx] = b;
    col_syndrome ^= b;
    if (fill_idx < DATA_ROWS) row_odd[fill_idx] = ^b;
    if (fill_idx == DATA_ROWS) begin
      count = BLOCK_LEN;
      if (col_syndrome != 8'h00 && !(first_fix_only && fixed_this_msg)) begin
        bit_pos = 0;
        while (!col_syndrome[bit_pos]) bit_pos++;
        for (int r = DATA_ROWS - 1; r >= 0; r--) begin
          if (row_odd[r]) fix_row = r;
        end
        if (fix_row >= 0) begin
          fixed_this_msg = 1'b1;
          mask = 8'h01 << bit_pos;
        end else begin
          chk = 1'b1;
        end
      end
    end else if (last) begin
      count = fill_idx + 1;
    end else begin
      fill_idx = fill_idx + 3'd1;
      return;
    end
    for (int k = 0; k < count; k++) begin
      bt.data = held_bytes[k] ^ ((k == fix_row) ? mask : 8'h00);
      bt.lor  = (k == count - 1);
      bt.eom  = last && (k == count - 1);
      bt.corr = (k == fix_row);
      bt.chk  = chk;
      corrected_due.push_back(bt);
    end
    fill_idx     = 3'd0;
    col_syndrome = 8'h00;
    row_odd      = '0;
    if (last) fixed_this_msg = 1'b0;
  endtask

  initial begin
    errors     = 0;
    fail_count = 0;
    beats_due  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      corrected_due.delete();
      fill_idx       = 3'd0;
      col_syndrome   = 8'h00;
      row_odd        = '0;
      fixed_this_msg = 1'b0;
      first_fix_only = 1'b1;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data = m_tdata;
        got.lor  = m_tlast;
        got.eom  = m_tuser[EOM_BIT];
        got.corr = m_tuser[CORR_BIT];
        got.chk  = m_tuser[CHK_BIT];
        if (corrected_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual %s",
                   $time, $sformatf("data=%h lor=%b eom=%b corr=%b chk=%b",
                   got.data, got.lor, got.eom, got.corr, got.chk));
        end else begin
          want = corrected_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: beat mismatch, expected data=%h lor=%b eom=%b corr=%b chk=%b",
                     $time, want.data, want.lor, want.eom, want.corr, want.chk);
            $display("%0t:                actual   data=%h lor=%b eom=%b corr=%b chk=%b",
                     $time, got.data, got.lor, got.eom, got.corr, got.chk);
          end
        end
      end
      if (cfg_we) first_fix_only = cfg_wdata;
      if (s_tvalid && s_tready) correct_block_byte(s_tdata, s_tlast);
    end
    // published through nonblocking assignments so readers never race this block
    beats_due  <= corrected_due.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages built from parity blocks (clean, single-bit, double-bit
// and garbage errors, with trailing partial blocks) into the 2-D parity
// corrector under several idle/stall mixes and both correction modes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;     // [7:0] data_byte
  logic        s_tlast;     // last_in_message
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;     // [7:0] out_byte
  logic        m_tlast;     // last_of_run
  logic [2:0]  m_tuser;     // [0] end_of_message [1] was_corrected [2] check_error

  int unsigned fail_count;
  int unsigned beats_due;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  logic [7:0]  msg_bytes[$];

  two_d_parity_block_corrector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  tdpc_scoreboard u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // hard stop; slowest legal run is far below this
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // one beat on the input side; random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // ship the queued bytes as one message, tlast on the final one
  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    msg_bytes.delete();
  endtask

  // six data rows (row 0 lowest) plus their column parity, then XOR the
  // error pattern over all seven bytes (parity byte in flips[55:48])
  task automatic add_block(input logic [47:0] rows, input logic [55:0] flips);
    logic [7:0] par;
    par = 8'h00;
    for (int i = 0; i < 6; i++) begin
      par ^= rows[8*i +: 8];
      msg_bytes.push_back(rows[8*i +: 8] ^ flips[8*i +: 8]);
    end
    msg_bytes.push_back(par ^ flips[55:48]);
  endtask

  // 0..3 blocks, mostly correctable, plus a 0..6 byte tail
  task automatic add_random_message();
    int          nblk;
    int          tail;
    int unsigned kind;
    logic [47:0] rows;
    logic [55:0] flips;
    nblk = $urandom_range(3, 0);
    tail = $urandom_range(6, 0);
    if (nblk == 0 && tail == 0) tail = 1;
    for (int b = 0; b < nblk; b++) begin
      kind = $urandom_range(99, 0);
      rows[31:0]  = $urandom();
      rows[47:32] = $urandom();
      flips = '0;
      if (kind < 30) begin
        // clean block
      end else if (kind < 75) begin
        flips[$urandom_range(55, 0)] = 1'b1;
      end else if (kind < 90) begin
        flips[$urandom_range(55, 0)] = 1'b1;
        flips[$urandom_range(55, 0)] = 1'b1;
      end else begin
        // noise: anything goes
        flips[31:0]  = $urandom();
        flips[55:32] = $urandom();
      end
      add_block(rows, flips);
    end
    for (int t = 0; t < tail; t++) msg_bytes.push_back($urandom_range(255, 0));
  endtask

  // drop valid, let every expected beat out, then allow the chain to settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(input logic first_only);
    cfg_we    <= 1'b1;
    cfg_wdata <= first_only;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // idle/stall mix and mode for one stretch of random messages
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input logic first_only, input int unsigned n_bytes);
    int unsigned start;
    drain();
    write_mode(first_only);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      add_random_message();
      send_message();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    s_tlast        = 1'b0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, full rate, first-fix-only mode ---
    write_mode(1'b1);

    // one-byte message: partial block, passes straight through
    msg_bytes.push_back(8'hFF);
    send_message();

    // block 1: row 3 and parity hit -> syndrome 0x28, lowest bit 3 fixes row 3
    // block 2: single error, but the message already had its fix -> untouched
    // then a two-byte tail as a trailing partial block
    add_block(48'h00_00_00_00_00_FF, 56'h20_00_00_08_00_00_00);
    add_block(48'h80_FF_00_01_AA_55, 56'h00_01_00_00_00_00_00);
    msg_bytes.push_back(8'h3C);
    msg_bytes.push_back(8'hC3);
    send_message();

    // all-zero rows, parity bit 7 set: syndrome with no odd row -> check error,
    // message ends on the parity beat
    add_block(48'h0, 56'h80_00_00_00_00_00_00);
    send_message();

    // --- random phases ---
    run_phase(0, 0, 1'b1, 40);      // no idling
    run_phase(76, 0, 1'b0, 45);     // sender mostly idle, fix every block
    run_phase(0, 76, 1'b1, 45);     // receiver mostly stalled
    run_phase(29, 29, 1'b0, 45);    // both sides idle at random

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== two_d_parity_block_corrector_unit.f =====
+incdir+design
design/tdpc_pkg.sv
design/tdpc_cell.sv
design/two_d_parity_block_corrector_unit.sv
design/tdpc_checker.sv
tb/sv/tdpc_checker.sv
tb/sv/testbench.sv
